>>> rtl/keq_pkg.sv
// Shared types and constants for the keypad event queue.
// No dependencies; the interfaces, keq_cfg, the top block and the testbench import this package.
`default_nettype none

package keq_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TIME_W     = 32;
  localparam int KEY_W      = 8;
  localparam int DEBOUNCE_W = 16;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd35;

  localparam logic [KEY_W-1:0] KEY_NONE = 8'h00;
  localparam logic [KEY_W-1:0] KEY_A    = 8'h41;
  localparam logic [KEY_W-1:0] KEY_B    = 8'h42;
  localparam logic [KEY_W-1:0] KEY_C    = 8'h43;
  localparam logic [KEY_W-1:0] KEY_D    = 8'h44;
  localparam logic [KEY_W-1:0] KEY_STAR = 8'h2A;
  localparam logic [KEY_W-1:0] KEY_HASH = 8'h23;
  localparam logic [KEY_W-1:0] KEY_0    = 8'h30;
  localparam logic [KEY_W-1:0] KEY_9    = 8'h39;

  // Register index, taken from paddr bit 2.
  typedef enum logic {
    REG_DEBOUNCE = 1'b0,
    REG_RAW_EN   = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    FUNC_KEY  = 2'd0,
    FUNC_MODE = 2'd1,
    FUNC_POP  = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    EV_MODE   = 3'd0,
    EV_ENROLL = 3'd1,
    EV_DELETE = 3'd2,
    EV_STATUS = 3'd3,
    EV_SLEEP  = 3'd4,
    EV_RAW    = 3'd5
  } ev_type_t;

  typedef struct packed {
    ev_type_t          ev_type;
    logic [KEY_W-1:0]  key;
    logic              mode;
    logic [TIME_W-1:0] stamp;
  } ev_entry_t;

  localparam int ENTRY_W = $bits(ev_entry_t);

endpackage

`default_nettype wire

>>> rtl/keq_in_if.sv
// Input channel of the keypad event queue: valid/ready plus the item fields.
// Depends on keq_pkg.
`default_nettype none

interface keq_in_if
  import keq_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [1:0]            func;
  logic [KEY_W-1:0]      key_code;
  logic [TIME_W-1:0]     now_ms;
  logic                  new_mode;
  logic                  emit_event;

  modport source (output valid, func, key_code, now_ms, new_mode, emit_event,
                  input ready);
  modport sink   (input valid, func, key_code, now_ms, new_mode, emit_event,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/keq_out_if.sv
// Result channel of the keypad event queue: valid/ready plus the result fields.
// Depends on keq_pkg.
`default_nettype none

interface keq_out_if
  import keq_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic                  event_valid;
  logic [2:0]            event_type;
  logic [KEY_W-1:0]      event_key;
  logic                  event_mode;
  logic [TIME_W-1:0]     event_time;
  logic                  current_mode;
  logic                  queue_nonempty;

  modport source (output valid, event_valid, event_type, event_key, event_mode,
                  event_time, current_mode, queue_nonempty,
                  input ready);
  modport sink   (input valid, event_valid, event_type, event_key, event_mode,
                  event_time, current_mode, queue_nonempty,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/keq_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module keq_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/keq_cfg.sv
// APB-style configuration registers: debounce interval and raw key enable.
// Depends on keq_pkg.
`default_nettype none

module keq_cfg
  import keq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [DEBOUNCE_W-1:0] debounce_ms,
  output logic                  raw_key_enable
);

  logic [DEBOUNCE_W-1:0] debounce_r;
  logic [DEBOUNCE_W-1:0] debounce_nxt;
  logic                  raw_en_r;
  logic                  raw_en_nxt;
  logic                  wr_hit;
  reg_idx_t              idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_hit = psel && penable && pwrite && pready;

  always_comb begin
    debounce_nxt = debounce_r;
    raw_en_nxt   = raw_en_r;
    if (wr_hit) begin
      unique case (idx)
        REG_DEBOUNCE: debounce_nxt = pwdata[DEBOUNCE_W-1:0];
        REG_RAW_EN:   raw_en_nxt   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEBOUNCE: prdata = {{(CFG_DATA_W-DEBOUNCE_W){1'b0}}, debounce_r};
      REG_RAW_EN:   prdata = {{(CFG_DATA_W-1){1'b0}}, raw_en_r};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
      raw_en_r   <= 1'b0;
    end else begin
      debounce_r <= debounce_nxt;
      raw_en_r   <= raw_en_nxt;
    end
  end

  assign debounce_ms    = debounce_r;
  assign raw_key_enable = raw_en_r;

endmodule

`default_nettype wire

>>> rtl/keypad_event_queue.sv
// Keypad event controller: debounces key presses, classifies them into events
// and keeps the events in a circular queue held in a one-port-write RAM.
// Depends on keq_pkg, keq_in_if, keq_out_if, keq_ram and keq_cfg.
//
// Key press, set-mode, empty-pop and unused-func items have their result
// registered on the accepting edge. A pop that returns an event first loads
// the RAM read register; S_READ then registers the result. The block takes
// a new item whenever it is not waiting on RAM data and the output register is
// empty or being taken in the same cycle. The queue holds QUEUE_DEPTH-1 events
// and drops the oldest one when full. The RAM needs no clearing after reset.

`default_nettype none

module keypad_event_queue
  import keq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  keq_in_if.sink                in_ch,
  keq_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == LAST_SLOT) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  logic [DEBOUNCE_W-1:0] debounce_ms;
  logic                  raw_key_enable;

  state_t            state_r, state_nxt;
  logic              mode_r, mode_nxt;
  logic [TIME_W-1:0] last_time_r, last_time_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;

  logic              out_valid_r, out_valid_nxt;
  ev_entry_t         out_ev_r, out_ev_nxt;
  logic              out_ev_valid_r, out_ev_valid_nxt;
  logic              out_cur_mode_r, out_cur_mode_nxt;
  logic              out_nonempty_r, out_nonempty_nxt;

  logic              accept;
  logic [TIME_W-1:0] gap;
  logic              press_ok;
  logic              push_en;
  ev_entry_t         push_ev;
  logic              start_read;
  logic [PTR_W-1:0]  wr_adv;
  logic [ENTRY_W-1:0] rd_data;
  ev_entry_t         rd_ev;

  keq_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (cfg_psel),
    .penable        (cfg_penable),
    .pwrite         (cfg_pwrite),
    .paddr          (cfg_paddr),
    .pwdata         (cfg_pwdata),
    .prdata         (cfg_prdata),
    .pready         (cfg_pready),
    .debounce_ms    (debounce_ms),
    .raw_key_enable (raw_key_enable)
  );

  keq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (push_en),
    .wr_addr (wr_ptr_r),
    .wr_data (push_ev),
    .rd_en   (start_read),
    .rd_addr (rd_ptr_r),
    .rd_data (rd_data)
  );

  assign rd_ev       = ev_entry_t'(rd_data);
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign gap         = in_ch.now_ms - last_time_r;
  assign press_ok    = (in_ch.key_code != KEY_NONE) &&
                       (gap >= {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ms});
  assign wr_adv      = next_slot(wr_ptr_r);

  // Item decode and event classification.
  always_comb begin
    mode_nxt         = mode_r;
    last_time_nxt    = last_time_r;
    push_en          = 1'b0;
    push_ev.ev_type  = EV_MODE;
    push_ev.key      = in_ch.key_code;
    push_ev.mode     = 1'b0;
    push_ev.stamp    = in_ch.now_ms;
    start_read       = 1'b0;
    if (accept) begin
      unique case (func_t'(in_ch.func))
        FUNC_KEY: begin
          if (press_ok) begin
            last_time_nxt = in_ch.now_ms;
            priority if (in_ch.key_code == KEY_A) begin
              mode_nxt = 1'b0;
              push_en  = 1'b1;
            end else if (in_ch.key_code == KEY_B) begin
              mode_nxt     = 1'b1;
              push_en      = 1'b1;
              push_ev.mode = 1'b1;
            end else if (in_ch.key_code == KEY_STAR) begin
              push_en         = 1'b1;
              push_ev.ev_type = EV_ENROLL;
            end else if (in_ch.key_code == KEY_HASH) begin
              push_en         = 1'b1;
              push_ev.ev_type = EV_DELETE;
            end else if (in_ch.key_code == KEY_C) begin
              push_en         = 1'b1;
              push_ev.ev_type = EV_STATUS;
            end else if (in_ch.key_code == KEY_D) begin
              push_en         = 1'b1;
              push_ev.ev_type = EV_SLEEP;
            end else if (raw_key_enable && in_ch.key_code >= KEY_0 &&
                         in_ch.key_code <= KEY_9) begin
              push_en         = 1'b1;
              push_ev.ev_type = EV_RAW;
            end else begin
            end
          end
        end
        FUNC_MODE: begin
          if (mode_r != in_ch.new_mode) begin
            mode_nxt = in_ch.new_mode;
            if (in_ch.emit_event) begin
              push_en      = 1'b1;
              push_ev.key  = in_ch.new_mode ? KEY_B : KEY_A;
              push_ev.mode = in_ch.new_mode;
            end
          end
        end
        FUNC_POP: begin
          start_read = (wr_ptr_r != rd_ptr_r);
        end
        default: ;
      endcase
    end
  end

  // Queue pointers; a push into a full queue drops the oldest event.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_en) begin
      wr_ptr_nxt = wr_adv;
      if (wr_adv == rd_ptr_r) begin
        rd_ptr_nxt = next_slot(rd_ptr_r);
      end
    end else if (start_read) begin
      rd_ptr_nxt = next_slot(rd_ptr_r);
    end
  end

  always_comb begin
    state_nxt        = state_r;
    out_valid_nxt    = out_valid_r;
    out_ev_nxt       = out_ev_r;
    out_ev_valid_nxt = out_ev_valid_r;
    out_cur_mode_nxt = out_cur_mode_r;
    out_nonempty_nxt = out_nonempty_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (start_read) begin
          state_nxt = S_READ;
        end else if (accept) begin
          out_valid_nxt    = 1'b1;
          out_ev_valid_nxt = 1'b0;
          out_ev_nxt       = '0;
          out_cur_mode_nxt = mode_nxt;
          out_nonempty_nxt = (wr_ptr_nxt != rd_ptr_nxt);
        end
      end
      S_READ: begin
        state_nxt        = S_IDLE;
        out_valid_nxt    = 1'b1;
        out_ev_valid_nxt = 1'b1;
        out_ev_nxt       = rd_ev;
        out_cur_mode_nxt = mode_r;
        out_nonempty_nxt = (wr_ptr_r != rd_ptr_r);
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= 1'b0;
      last_time_r <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      last_time_r <= last_time_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ev_r       <= out_ev_nxt;
    out_ev_valid_r <= out_ev_valid_nxt;
    out_cur_mode_r <= out_cur_mode_nxt;
    out_nonempty_r <= out_nonempty_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.event_valid    = out_ev_valid_r;
  assign out_ch.event_type     = out_ev_r.ev_type;
  assign out_ch.event_key      = out_ev_r.key;
  assign out_ch.event_mode     = out_ev_r.mode;
  assign out_ch.event_time     = out_ev_r.stamp;
  assign out_ch.current_mode   = out_cur_mode_r;
  assign out_ch.queue_nonempty = out_nonempty_r;

endmodule

`default_nettype wire

>>> verif/keypad_event_queue_tb.sv
// Self-checking testbench for keypad_event_queue: directed and random key, mode and pop items,
// checked against a predictor of the debounce logic and the event queue.
// Depends on keq_pkg, keq_in_if, keq_out_if and the RTL of the block.

module keypad_event_queue_tb
  import keq_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = 32;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] SPECIAL_KEYS [6] = '{KEY_A, KEY_B, KEY_C, KEY_D, KEY_STAR,
                                                   KEY_HASH};

  typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_style_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic              nm;
    logic              emit;
  } kp_item_t;

  typedef struct packed {
    logic              ev_valid;
    logic [2:0]        ev_type;
    logic [KEY_W-1:0]  key;
    logic              mode;
    logic [TIME_W-1:0] stamp;
    logic              cur_mode;
    logic              nonempty;
  } outcome_t;

  class keypad_event_tracker;
    logic [DEBOUNCE_W-1:0] debounce;
    logic                  raw_en;
    logic                  mode;
    logic [TIME_W-1:0]     last_press;
    int                    wr;
    int                    rd;
    ev_entry_t             event_ring [QDEPTH];
    outcome_t              outcomes_due [$];
    int                    fails;

    function new();
      debounce = DEBOUNCE_RESET;
      raw_en = 1'b0;
      mode = 1'b0;
      last_press = '0;
      wr = 0;
      rd = 0;
      fails = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_DEBOUNCE) begin
        debounce = data[DEBOUNCE_W-1:0];
      end else begin
        raw_en = data[0];
      end
    endfunction

    function void push_event(ev_type_t t, logic [KEY_W-1:0] k, logic m, logic [TIME_W-1:0] s);
      int nw;
      nw = (wr + 1) % QDEPTH;
      if (nw == rd) begin
        rd = (rd + 1) % QDEPTH;
      end
      event_ring[wr] = '{ev_type: t, key: k, mode: m, stamp: s};
      wr = nw;
    endfunction

    function void take_item(kp_item_t it);
      outcome_t res;
      logic [TIME_W-1:0] gap;
      res = '0;
      case (it.func)
        FUNC_KEY: begin
          gap = it.now - last_press;
          if (it.key != KEY_NONE && gap >= {16'd0, debounce}) begin
            last_press = it.now;
            if (it.key == KEY_A) begin
              mode = 1'b0;
              push_event(EV_MODE, it.key, 1'b0, it.now);
            end else if (it.key == KEY_B) begin
              mode = 1'b1;
              push_event(EV_MODE, it.key, 1'b1, it.now);
            end else if (it.key == KEY_STAR) begin
              push_event(EV_ENROLL, it.key, 1'b0, it.now);
            end else if (it.key == KEY_HASH) begin
              push_event(EV_DELETE, it.key, 1'b0, it.now);
            end else if (it.key == KEY_C) begin
              push_event(EV_STATUS, it.key, 1'b0, it.now);
            end else if (it.key == KEY_D) begin
              push_event(EV_SLEEP, it.key, 1'b0, it.now);
            end else if (raw_en && it.key >= KEY_0 && it.key <= KEY_9) begin
              push_event(EV_RAW, it.key, 1'b0, it.now);
            end
          end
        end
        FUNC_MODE: begin
          if (mode != it.nm) begin
            mode = it.nm;
            if (it.emit) begin
              push_event(EV_MODE, it.nm ? KEY_B : KEY_A, it.nm, it.now);
            end
          end
        end
        FUNC_POP: begin
          if (wr != rd) begin
            res.ev_valid = 1'b1;
            res.ev_type = event_ring[rd].ev_type;
            res.key = event_ring[rd].key;
            res.mode = event_ring[rd].mode;
            res.stamp = event_ring[rd].stamp;
            rd = (rd + 1) % QDEPTH;
          end
        end
        default: ;
      endcase
      res.cur_mode = mode;
      res.nonempty = (wr != rd);
      outcomes_due.push_back(res);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        fails++;
      end
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      if (outcomes_due.size() == 0) begin
        $error("result item arrived with no item pending");
        fails++;
        return;
      end
      want = outcomes_due.pop_front();
      check_field("event_valid", 32'(want.ev_valid), 32'(got.ev_valid));
      check_field("event_type", 32'(want.ev_type), 32'(got.ev_type));
      check_field("event_key", 32'(want.key), 32'(got.key));
      check_field("event_mode", 32'(want.mode), 32'(got.mode));
      check_field("event_time", want.stamp, got.stamp);
      check_field("current_mode", 32'(want.cur_mode), 32'(got.cur_mode));
      check_field("queue_nonempty", 32'(want.nonempty), 32'(got.nonempty));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  keq_in_if  in_ch ();
  keq_out_if out_ch ();

  keypad_event_tracker tracker = new();
  logic [TIME_W-1:0] now_track;
  int burst_left;
  bit hold_out;
  int idle_cycles;

  keypad_event_queue i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        tracker.check_outcome(outcome_t'({out_ch.event_valid, out_ch.event_type,
                                          out_ch.event_key, out_ch.event_mode,
                                          out_ch.event_time, out_ch.current_mode,
                                          out_ch.queue_nonempty}));
      end
      if (in_ch.valid && in_ch.ready === 1'b1) begin
        tracker.take_item('{func: in_ch.func, key: in_ch.key_code, now: in_ch.now_ms,
                            nm: in_ch.new_mode, emit: in_ch.emit_event});
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready === 1'b1) begin
        tracker.set_reg(reg_idx_t'(cfg_paddr[2]), cfg_pwdata);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rx_style_t style;
    int pattern_left;
    style = RX_ALWAYS;
    pattern_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        if (pattern_left <= 0) begin
          style = rx_style_t'($urandom_range(0, 3));
          pattern_left = $urandom_range(16, 80);
        end
        pattern_left--;
        case (style)
          RX_ALWAYS: out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  function automatic kp_item_t kp(logic [1:0] func, logic [KEY_W-1:0] key,
                                  logic [TIME_W-1:0] now, logic nm, logic emit);
    kp_item_t it;
    it = '{func: func, key: key, now: now, nm: nm, emit: emit};
    return it;
  endfunction

  function automatic kp_item_t make_item(int pop_pct, logic [DEBOUNCE_W-1:0] deb);
    kp_item_t it;
    int r;
    it.nm = 1'($urandom_range(0, 1));
    it.emit = 1'($urandom_range(0, 1));
    it.key = KEY_W'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 65) begin
      now_track = now_track + deb + $urandom_range(0, 50);
    end else if (r < 85) begin
      now_track = now_track + $urandom_range(0, deb);
    end else if (r < 95) begin
      now_track = now_track + $urandom_range(0, 3);
    end else begin
      now_track = $urandom;
    end
    it.now = now_track;
    r = $urandom_range(0, 99);
    if (r < pop_pct) begin
      it.func = FUNC_POP;
    end else begin
      r = $urandom_range(0, 99);
      it.func = (r < 75) ? FUNC_KEY : (r < 95) ? FUNC_MODE : FUNC_UNUSED;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        it.key = KEY_NONE;
      end else if (r < 25) begin
        it.key = KEY_W'($urandom_range(0, 255));
      end else if (r < 50) begin
        it.key = KEY_0 + KEY_W'($urandom_range(0, 9));
      end else begin
        it.key = SPECIAL_KEYS[$urandom_range(0, 5)];
      end
    end
    return it;
  endfunction

  task automatic send_item(kp_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.func <= it.func;
    in_ch.key_code <= it.key;
    in_ch.now_ms <= it.now;
    in_ch.new_mode <= it.nm;
    in_ch.emit_event <= it.emit;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic offer(kp_item_t it, bit gaps_on);
    int gap;
    send_item(it);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 6);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.outcomes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(logic [DEBOUNCE_W-1:0] deb, logic raw);
    settle();
    cfg_write(REG_DEBOUNCE, {16'd0, deb});
    cfg_write(REG_RAW_EN, {31'd0, raw});
  endtask

  task automatic run_phase(logic [DEBOUNCE_W-1:0] deb, logic raw, int n, int pop_pct,
                           logic [TIME_W-1:0] start_ms);
    program_regs(deb, raw);
    now_track = start_ms;
    repeat (n) offer(make_item(pop_pct, deb), 1'b1);
  endtask

  initial begin
    kp_item_t plan [$];
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FUNC_KEY;
    in_ch.key_code <= KEY_NONE;
    in_ch.now_ms <= '0;
    in_ch.new_mode <= 1'b0;
    in_ch.emit_event <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    hold_out = 1'b0;
    burst_left = 0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: debounce boundary, every key class, mode items, empty pop, unused func.
    plan = '{kp(FUNC_POP, KEY_NONE, 32'd0, 1'b0, 1'b0),
             kp(FUNC_UNUSED, KEY_A, 32'd50, 1'b1, 1'b1),
             kp(FUNC_KEY, KEY_NONE, 32'd1000, 1'b0, 1'b0),
             kp(FUNC_KEY, KEY_A, 32'd100, 1'b0, 1'b0),
             kp(FUNC_KEY, KEY_B, 32'd200, 1'b0, 1'b0),
             kp(FUNC_KEY, KEY_STAR, 32'd210, 1'b0, 1'b0),
             kp(FUNC_KEY, KEY_STAR, 32'd235, 1'b0, 1'b0),
             kp(FUNC_KEY, KEY_HASH, 32'd300, 1'b0, 1'b0),
             kp(FUNC_KEY, KEY_C, 32'd400, 1'b0, 1'b0),
             kp(FUNC_KEY, KEY_D, 32'd500, 1'b0, 1'b0),
             kp(FUNC_KEY, KEY_0 + 8'd5, 32'd600, 1'b0, 1'b0),
             kp(FUNC_KEY, 8'hFF, 32'd700, 1'b0, 1'b0),
             kp(FUNC_MODE, KEY_NONE, 32'd710, 1'b1, 1'b1),
             kp(FUNC_MODE, KEY_NONE, 32'd720, 1'b0, 1'b1),
             kp(FUNC_MODE, KEY_NONE, 32'd730, 1'b1, 1'b0),
             kp(FUNC_POP, KEY_NONE, 32'd740, 1'b0, 1'b0),
             kp(FUNC_POP, KEY_NONE, 32'd750, 1'b0, 1'b0)};
    foreach (plan[i]) offer(plan[i], 1'b1);

    // Raw keys on with no debounce, then the widest debounce across the time wrap.
    program_regs(16'd0, 1'b1);
    plan = '{kp(FUNC_KEY, KEY_0, 32'hFFFF_FFFF, 1'b0, 1'b0),
             kp(FUNC_KEY, KEY_9, 32'hFFFF_FFFF, 1'b0, 1'b0),
             kp(FUNC_KEY, KEY_0 - 8'd1, 32'hFFFF_FFFF, 1'b0, 1'b0),
             kp(FUNC_KEY, KEY_9 + 8'd1, 32'hFFFF_FFFF, 1'b0, 1'b0),
             kp(FUNC_KEY, KEY_STAR, 32'hFFFF_FFFF, 1'b0, 1'b0),
             kp(FUNC_KEY, KEY_HASH, 32'hFFFF_FFFF, 1'b0, 1'b0)};
    foreach (plan[i]) offer(plan[i], 1'b1);
    program_regs(16'hFFFF, 1'b1);
    plan = '{kp(FUNC_KEY, KEY_C, 32'h0000_FFFE, 1'b0, 1'b0),
             kp(FUNC_KEY, KEY_D, 32'h0001_FFFC, 1'b0, 1'b0)};
    foreach (plan[i]) offer(plan[i], 1'b1);

    run_phase(16'd0, 1'b1, 150, 30, $urandom);
    run_phase(16'd35, 1'b0, 120, 10, 32'd0);

    // The receiver holds off while the sender streams, so the block fills and stalls.
    settle();
    hold_out = 1'b1;
    now_track = $urandom;
    repeat (80) offer(make_item(5, 16'd35), 1'b0);

    run_phase(16'hFFFF, 1'b1, 120, 35, 32'hFFF0_0000);
    run_phase(DEBOUNCE_W'($urandom_range(1, 500)), 1'b1, 150, 25, $urandom);
    run_phase(16'd1, 1'b0, 100, 50, $urandom);

    settle();
    repeat (10) @(posedge clk);
    if (tracker.fails == 0 && tracker.outcomes_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> keypad_event_queue.f
rtl/keq_pkg.sv
rtl/keq_in_if.sv
rtl/keq_out_if.sv
rtl/keq_ram.sv
rtl/keq_cfg.sv
rtl/keypad_event_queue.sv
verif/keypad_event_queue_tb.sv
